/* hdl/tcta_pkg.sv */
package tcta_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int TIMER_BITS = 24;

    localparam int TASK_IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int COUNT_W    = $clog2(MAX_TASKS + 1);
    localparam int TOTAL_W    = 32;
    localparam int RELOAD_W   = 25;
    localparam int WINDOW_W   = 16;
    localparam int DEPTH_W    = 8;
    localparam int ID_W       = 4;
    localparam int TVALUE_W   = 24;
    localparam int ACTION_W   = 3;
    // last - now spans +/- 2^24, plus reload: two guard bits over a total
    localparam int ALU_W      = TOTAL_W + 2;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 80;
    localparam int CFG_IDX_W  = 1;

    localparam logic [RELOAD_W-1:0] RELOAD_RST = RELOAD_W'(72000);
    localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SWAP      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_IRQ_BEGIN = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_IRQ_END   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CREATE    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FREE      = 3'd5;

    typedef enum logic [1:0] {
        ALU_SUB       = 2'd0,
        ALU_ADD_CLAMP = 2'd1,
        ALU_ADD_SAT   = 2'd2
    } alu_op_t;

endpackage

/* hdl/task_cpu_time_accounting.sv */
// Per-task CPU time accounting.
// Input channel s_*: one event per transfer. s_tuser carries the action, s_tdata
// the task id, the irq-bucket flag and the sampled down-counting timer value.
// Output channel m_*: exactly one result per event, holding the live task count,
// the interrupt and addressed-task totals of the last complete window and the
// interrupt nesting depth after the event.
// Configuration: cfg_we/cfg_index/cfg_data write timer_reload (0) or window_ticks (1).
// Event handling, from one accepted transfer to the next possible one:
//   charging events (swap out, outermost irq entry/exit) make three passes
//     through the shared adder (elapsed, wrap correction, saturating sum);
//   other events go from dispatch straight to the result;
//   a tick that closes a window sweeps the table, one table entry per cycle.
// A new event is taken only after the result of the last one has been loaded.
// The result is registered; s_tready returns while it waits, so a stalled receiver
// holds up the block only when the next result is ready to be loaded.
// Reset clears all totals, marks, counters and depth, and loads the register defaults.
module task_cpu_time_accounting
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] task_id, [4] to_irq_bucket, [28:5] timer_value, [31:29] zero
    input  logic [tcta_pkg::S_TDATA_W-1:0]      s_tdata,
    // [2:0] action
    input  logic [tcta_pkg::ACTION_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [4:0] task_count, [36:5] irq_window_cycles, [68:37] task_window_cycles,
    // [76:69] irq_depth, [79:77] zero
    output logic [tcta_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [tcta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcta_pkg::RELOAD_W-1:0]       cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_ELAPSED  = 7'b0000100,
        S_WRAP     = 7'b0001000,
        S_ACCUM    = 7'b0010000,
        S_SWEEP    = 7'b0100000,
        S_RESULT   = 7'b1000000
    } state_t;

    localparam logic [tcta_pkg::TASK_IDX_W-1:0] SWEEP_LAST =
        tcta_pkg::TASK_IDX_W'(tcta_pkg::MAX_TASKS - 1);
    localparam logic [tcta_pkg::COUNT_W-1:0] COUNT_MAX =
        tcta_pkg::COUNT_W'(tcta_pkg::MAX_TASKS);
    localparam logic [tcta_pkg::DEPTH_W-1:0] DEPTH_MAX = '1;

    state_t state_reg, state_next;

    logic [tcta_pkg::RELOAD_W-1:0]   reload_reg;
    logic [tcta_pkg::WINDOW_W-1:0]   window_reg;

    logic [tcta_pkg::ACTION_W-1:0]   action_reg;
    logic [tcta_pkg::ID_W-1:0]       id_reg;
    logic                            to_irq_reg;
    logic [tcta_pkg::TIMER_BITS-1:0] now_reg;
    logic                            charge_irq_reg, charge_irq_next;

    logic [tcta_pkg::TIMER_BITS-1:0] last_timer_reg, last_timer_next;
    logic [tcta_pkg::WINDOW_W-1:0]   tick_reg, tick_next;
    logic [tcta_pkg::DEPTH_W-1:0]    depth_reg, depth_next;
    logic [tcta_pkg::COUNT_W-1:0]    live_reg, live_next;
    logic [tcta_pkg::TASK_IDX_W-1:0] sweep_reg, sweep_next;
    logic [tcta_pkg::ALU_W-1:0]      acc_reg, acc_next;
    logic [tcta_pkg::TOTAL_W-1:0]    irq_run_reg, irq_run_next;
    logic [tcta_pkg::TOTAL_W-1:0]    irq_last_reg, irq_last_next;

    logic                            active_reg [tcta_pkg::MAX_TASKS];
    logic [tcta_pkg::TOTAL_W-1:0]    run_reg    [tcta_pkg::MAX_TASKS];
    logic [tcta_pkg::TOTAL_W-1:0]    last_reg   [tcta_pkg::MAX_TASKS];

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [tcta_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                            s_xfer;
    logic [tcta_pkg::TASK_IDX_W-1:0] id_idx;
    logic                            id_ok;
    logic [tcta_pkg::TASK_IDX_W-1:0] arr_idx;
    logic                            active_rd;
    logic [tcta_pkg::TOTAL_W-1:0]    run_rd;
    logic [tcta_pkg::TOTAL_W-1:0]    task_win;
    logic [tcta_pkg::WINDOW_W-1:0]   tick_inc;
    logic                            acc_le0;
    logic                            out_load;

    logic                            tbl_mark;
    logic                            tbl_mark_val;
    logic                            tbl_charge;
    logic                            tbl_sweep;

    tcta_pkg::alu_op_t               alu_op;
    logic [tcta_pkg::ALU_W-1:0]      alu_a, alu_b, alu_y;

    tcta_alu u_alu
    (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign id_idx    = tcta_pkg::TASK_IDX_W'(id_reg);
    assign id_ok     = (32'(id_reg) < tcta_pkg::MAX_TASKS);
    assign arr_idx   = (state_reg == S_SWEEP) ? sweep_reg : id_idx;
    assign active_rd = active_reg[arr_idx];
    assign run_rd    = run_reg[arr_idx];
    assign task_win  = id_ok ? last_reg[id_idx] : '0;
    assign tick_inc  = tick_reg + 1'b1;
    assign acc_le0   = acc_reg[tcta_pkg::ALU_W-1] || (acc_reg == '0);
    assign out_load  = (state_reg == S_RESULT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        alu_op = tcta_pkg::ALU_SUB;
        alu_a  = acc_reg;
        alu_b  = tcta_pkg::ALU_W'(reload_reg);
        unique case (state_reg)
            S_ELAPSED:
            begin
                alu_op = tcta_pkg::ALU_SUB;
                alu_a  = tcta_pkg::ALU_W'(last_timer_reg);
                alu_b  = tcta_pkg::ALU_W'(now_reg);
            end
            S_WRAP:
            begin
                alu_op = tcta_pkg::ALU_ADD_CLAMP;
                alu_a  = acc_reg;
                alu_b  = tcta_pkg::ALU_W'(reload_reg);
            end
            S_ACCUM:
            begin
                alu_op = tcta_pkg::ALU_ADD_SAT;
                alu_a  = tcta_pkg::ALU_W'(charge_irq_reg ? irq_run_reg : run_rd);
                alu_b  = acc_reg;
            end
            default:
            begin
                alu_op = tcta_pkg::ALU_SUB;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        charge_irq_next = charge_irq_reg;
        last_timer_next = last_timer_reg;
        tick_next       = tick_reg;
        depth_next      = depth_reg;
        live_next       = live_reg;
        sweep_next      = sweep_reg;
        acc_next        = acc_reg;
        irq_run_next    = irq_run_reg;
        irq_last_next   = irq_last_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        tbl_mark        = 1'b0;
        tbl_mark_val    = 1'b0;
        tbl_charge      = 1'b0;
        tbl_sweep       = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                state_next = S_RESULT;
                case (action_reg)
                    tcta_pkg::ACT_TICK:
                    begin
                        if (tick_inc < window_reg)
                        begin
                            tick_next = tick_inc;
                        end
                        else
                        begin
                            tick_next  = '0;
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                    end
                    tcta_pkg::ACT_SWAP:
                    begin
                        charge_irq_next = to_irq_reg;
                        state_next      = S_ELAPSED;
                    end
                    tcta_pkg::ACT_IRQ_BEGIN:
                    begin
                        if (depth_reg == '0)
                        begin
                            charge_irq_next = 1'b0;
                            state_next      = S_ELAPSED;
                        end
                        if (depth_reg != DEPTH_MAX)
                            depth_next = depth_reg + 1'b1;
                    end
                    tcta_pkg::ACT_IRQ_END:
                    begin
                        if (depth_reg != '0)
                        begin
                            if (depth_reg == tcta_pkg::DEPTH_W'(1))
                            begin
                                charge_irq_next = 1'b1;
                                state_next      = S_ELAPSED;
                            end
                            depth_next = depth_reg - 1'b1;
                        end
                    end
                    tcta_pkg::ACT_CREATE:
                    begin
                        if (id_ok && !active_rd)
                        begin
                            tbl_mark     = 1'b1;
                            tbl_mark_val = 1'b1;
                            if (live_reg < COUNT_MAX)
                                live_next = live_reg + 1'b1;
                        end
                    end
                    tcta_pkg::ACT_FREE:
                    begin
                        if (id_ok && active_rd)
                        begin
                            tbl_mark     = 1'b1;
                            tbl_mark_val = 1'b0;
                            if (live_reg != '0)
                                live_next = live_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_ELAPSED:
            begin
                acc_next   = alu_y;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                // timer wrapped (or did not move): add one period, floor at zero
                if (acc_le0)
                    acc_next = alu_y;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (charge_irq_reg)
                    irq_run_next = tcta_pkg::TOTAL_W'(alu_y);
                else if (id_ok && active_rd)
                    tbl_charge = 1'b1;
                last_timer_next = now_reg;
                state_next      = S_RESULT;
            end
            S_SWEEP:
            begin
                tbl_sweep = active_rd;
                if (sweep_reg == SWEEP_LAST)
                begin
                    irq_last_next = irq_run_reg;
                    irq_run_next  = '0;
                    state_next    = S_RESULT;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, depth_reg, task_win, irq_last_reg,
                                     5'(live_reg)};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            reload_reg     <= tcta_pkg::RELOAD_RST;
            window_reg     <= tcta_pkg::WINDOW_RST;
            charge_irq_reg <= 1'b0;
            last_timer_reg <= '0;
            tick_reg       <= '0;
            depth_reg      <= '0;
            live_reg       <= '0;
            sweep_reg      <= '0;
            irq_run_reg    <= '0;
            irq_last_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            charge_irq_reg <= charge_irq_next;
            last_timer_reg <= last_timer_next;
            tick_reg       <= tick_next;
            depth_reg      <= depth_next;
            live_reg       <= live_next;
            sweep_reg      <= sweep_next;
            irq_run_reg    <= irq_run_next;
            irq_last_reg   <= irq_last_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcta_pkg::CFG_TIMER_RELOAD: reload_reg <= cfg_data;
                    tcta_pkg::CFG_WINDOW_TICKS: window_reg <= cfg_data[tcta_pkg::WINDOW_W-1:0];
                    default:                    reload_reg <= reload_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
        if (s_xfer)
        begin
            action_reg <= s_tuser;
            id_reg     <= s_tdata[tcta_pkg::ID_W-1:0];
            to_irq_reg <= s_tdata[tcta_pkg::ID_W];
            now_reg    <= tcta_pkg::TIMER_BITS'(
                s_tdata[tcta_pkg::ID_W+tcta_pkg::TVALUE_W:tcta_pkg::ID_W+1]);
        end
    end

    // task table: one entry touched per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcta_pkg::MAX_TASKS; i++)
            begin
                active_reg[i] <= 1'b0;
                run_reg[i]    <= '0;
                last_reg[i]   <= '0;
            end
        end
        else
        begin
            if (tbl_mark)
            begin
                active_reg[id_idx] <= tbl_mark_val;
                run_reg[id_idx]    <= '0;
                last_reg[id_idx]   <= '0;
            end
            if (tbl_charge)
                run_reg[id_idx] <= tcta_pkg::TOTAL_W'(alu_y);
            if (tbl_sweep)
            begin
                last_reg[sweep_reg] <= run_reg[sweep_reg];
                run_reg[sweep_reg]  <= '0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    logic [tcta_pkg::MAX_TASKS-1:0] active_vec;

    always_comb
    begin
        for (int i = 0; i < tcta_pkg::MAX_TASKS; i++)
            active_vec[i] = active_reg[i];
    end

    a_live_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_vec) == 32'(live_reg))
        else $error("live task count differs from active marks");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_tready)
        else $error("input accepted while an event is in progress");

    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && sweep_reg == SWEEP_LAST) |=> (state_reg == S_RESULT))
        else $error("window sweep did not finish after the last entry");
`endif

endmodule

/* hdl/tcta_alu.sv */
module tcta_alu
(
    input  tcta_pkg::alu_op_t               op,
    input  logic [tcta_pkg::ALU_W-1:0]      a,
    input  logic [tcta_pkg::ALU_W-1:0]      b,
    output logic [tcta_pkg::ALU_W-1:0]      y
);

    logic [tcta_pkg::ALU_W-1:0] b_eff;
    logic [tcta_pkg::ALU_W-1:0] sum;
    logic                       sub;

    // single adder; subtract is a + ~b + 1
    assign sub   = (op == tcta_pkg::ALU_SUB);
    assign b_eff = sub ? ~b : b;
    assign sum   = a + b_eff + tcta_pkg::ALU_W'(sub);

    always_comb
    begin
        unique case (op)
            tcta_pkg::ALU_SUB:
            begin
                y = sum;
            end
            tcta_pkg::ALU_ADD_CLAMP:
            begin
                y = sum[tcta_pkg::ALU_W-1] ? '0 : sum;
            end
            tcta_pkg::ALU_ADD_SAT:
            begin
                // operands are non-negative: any bit above the total width is overflow
                if (sum[tcta_pkg::ALU_W-1:tcta_pkg::TOTAL_W] != '0)
                    y = {{(tcta_pkg::ALU_W-tcta_pkg::TOTAL_W){1'b0}},
                         {tcta_pkg::TOTAL_W{1'b1}}};
                else
                    y = sum;
            end
            default:
            begin
                y = sum;
            end
        endcase
    end

endmodule
